// File: design/aes128_pkg.sv
// Package for the AES-128 block cipher unit.
// Holds the S-box tables, GF(2^8) helpers and round functions; no dependencies.
package aes128_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned WordW  = 32;
  localparam int unsigned HalfW  = 64;

  typedef enum logic [0:0] {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } aes_op_e;

  localparam logic [0:0] RegKeyUpper = 1'b0;
  localparam logic [0:0] RegKeyLower = 1'b1;

  localparam logic [7:0] ByteMask = 8'hFF;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block sits at bits 127-8i .. 120-8i.
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int i);
    return s[BlockW-1-8*i -: 8];
  endfunction

  // Forward MixColumns on one column (bytes a0..a3 from top row).
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, t;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    t = a0 ^ a1 ^ a2 ^ a3;
    return {a0 ^ t ^ xtime(a0 ^ a1), a1 ^ t ^ xtime(a1 ^ a2),
            a2 ^ t ^ xtime(a2 ^ a3), a3 ^ t ^ xtime(a3 ^ a0)};
  endfunction

  // Inverse MixColumns: premultiply then reuse the forward matrix.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  // SubWord with RotWord folded in.
  function automatic logic [31:0] sub_rot_word(input logic [31:0] w);
    return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

endpackage

// File: design/aes128_round.sv
// One shared AES round datapath, forward or inverse, used once per cycle.
// Depends on aes128_pkg for the S-boxes and column mixing functions.
module aes128_round (
  input  logic                        inv_i,
  input  logic                        last_i,
  input  logic [aes128_pkg::BlockW-1:0] state_i,
  input  logic [aes128_pkg::BlockW-1:0] rkey_i,
  output logic [aes128_pkg::BlockW-1:0] state_o
);
  import aes128_pkg::*;

  logic [BlockW-1:0] sh_s, sb_s, ak_s, mc_s;

  // ShiftRows then SubBytes (these commute) in the chosen direction.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sh_s[BlockW-1-8*(4*c+r) -: 8] = inv_i ?
          get_byte(state_i, r + 4*((c + 3*r) % 4)) :
          get_byte(state_i, r + 4*((c + r) % 4));
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb_s[BlockW-1-8*i -: 8] = inv_i ? INV_SBOX[get_byte(sh_s, i)]
                                      : SBOX[get_byte(sh_s, i)];
    end
  end

  // Encrypt: mix then add key. Decrypt: add key then inverse mix. Last round: add key only.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mc_s[BlockW-1-32*c -: 32] = mix_col(sb_s[BlockW-1-32*c -: 32]);
    end
    ak_s = sb_s ^ rkey_i;
    if (last_i) begin
      state_o = ak_s;
    end else if (inv_i) begin
      for (int c = 0; c < 4; c++) begin
        state_o[BlockW-1-32*c -: 32] = inv_mix_col(ak_s[BlockW-1-32*c -: 32]);
      end
    end else begin
      state_o = mc_s ^ rkey_i;
    end
  end

endmodule

// File: design/aes128_block_cipher_unit.sv
// AES-128 block cipher unit: top level with key schedule and round sequencer.
// Depends on aes128_pkg and aes128_round.
//
// A block is accepted when the unit is idle and no key write is present. From
// acceptance to its result, the unit does the initial key addition, then the
// ten rounds on the shared round datapath, then loads the output register.
// The next block can be accepted the cycle after that load, so the unit does
// not take a new block before the last one is loaded. A key write rebuilds the
// 44-word schedule one word per cycle and stores each finished round key.
// Blocks are not accepted during the sweep. After reset the same sweep runs
// for the all-zero key. The result stays in its output register until
// transferred, and a new block is accepted while it waits.
module aes128_block_cipher_unit #(
  parameter int unsigned ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [63:0] block_upper_i,
  input  logic [63:0] block_lower_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_upper_o,
  output logic [63:0] out_lower_o
);
  import aes128_pkg::*;

  localparam int unsigned NumWords = 4 * (ROUNDS + 1);
  localparam int unsigned WIdxW    = $clog2(NumWords + 1);
  localparam int unsigned RndW     = $clog2(ROUNDS + 1);

  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [63:0]         key_hi_q, key_lo_q;
  logic [BlockW-1:0]   rk_mem [ROUNDS + 1];
  logic [WIdxW-1:0]    widx_q;
  logic [7:0]          rcon_q;
  logic [4*WordW-1:0]  win_q;
  logic [RndW-1:0]     rnd_q;
  logic                inv_q;
  logic [BlockW-1:0]   blk_q;
  logic [BlockW-1:0]   rkey_q;
  logic                ovalid_q;
  logic [BlockW-1:0]   out_q;
  logic [BlockW-1:0]   rnd_out;
  logic [WordW-1:0]    new_word;
  logic                in_xfer, out_xfer, cfg_hit, last_rnd, load_out;
  logic [RndW-1:0]     rnd_next, key_rnd;
  logic [RndW-1:0]     rd_rnd, wr_rnd;

  // Key schedule: next word from the sliding window of the last four words.
  always_comb begin
    if (widx_q[1:0] == 2'd0) begin
      new_word = win_q[4*WordW-1 -: WordW] ^ sub_rot_word(win_q[WordW-1:0])
                 ^ {rcon_q, 24'd0};
    end else begin
      new_word = win_q[4*WordW-1 -: WordW] ^ win_q[WordW-1:0];
    end
  end

  assign cfg_hit  = cfg_we_i && (cfg_index_i == RegKeyUpper || cfg_index_i == RegKeyLower);
  assign in_stall_o = (state_q != ST_IDLE) || cfg_we_i;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = ovalid_q && !out_stall_i;
  assign last_rnd = (rnd_q == RndW'(ROUNDS));
  assign rnd_next = rnd_q + RndW'(1);
  assign key_rnd  = inv_q ? RndW'(ROUNDS) - rnd_next : rnd_next;
  assign load_out = (state_q == ST_DONE) && (!ovalid_q || out_xfer);

  aes128_round u_round (
    .inv_i   (inv_q),
    .last_i  (last_rnd),
    .state_i (blk_q),
    .rkey_i  (rkey_q),
    .state_o (rnd_out)
  );

  // Round-key store: each time the window holds four new words, it is one
  // finished round key and is written as a whole.
  assign wr_rnd = RndW'(widx_q[WIdxW-1:2]) - RndW'(1);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXPAND && widx_q[1:0] == 2'd0 && widx_q != '0) begin
      rk_mem[wr_rnd] <= win_q;
    end
  end

  // One round key is read per cycle, ahead of the round that uses it.
  always_comb begin
    if (in_xfer) begin
      rd_rnd = opcode_i ? RndW'(ROUNDS) : RndW'(0);
    end else if (state_q == ST_ROUND && !last_rnd) begin
      rd_rnd = key_rnd;
    end else begin
      rd_rnd = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_q <= rk_mem[rd_rnd];
  end

  // Sequencer: schedule sweep, idle, rounds, output load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_EXPAND;
      key_hi_q <= '0;
      key_lo_q <= '0;
      widx_q   <= '0;
      rcon_q   <= 8'h01;
      win_q    <= '0;
      rnd_q    <= '0;
      inv_q    <= 1'b0;
    end else begin
      if (cfg_hit) begin
        // Restart the sweep from the updated key halves.
        if (cfg_index_i == RegKeyUpper) key_hi_q <= cfg_data_i;
        else key_lo_q <= cfg_data_i;
        state_q <= ST_EXPAND;
        widx_q  <= '0;
        rcon_q  <= 8'h01;
        win_q   <= (cfg_index_i == RegKeyUpper) ? {cfg_data_i, key_lo_q}
                                                : {key_hi_q, cfg_data_i};
      end else begin
        case (state_q)
          ST_EXPAND: begin
            if (widx_q == '0) begin
              win_q <= {key_hi_q, key_lo_q};
            end
            if (widx_q < WIdxW'(4)) begin
              // First four words are the key itself and already sit in the window.
              widx_q <= widx_q + WIdxW'(1);
            end else if (widx_q < WIdxW'(NumWords)) begin
              win_q  <= {win_q[3*WordW-1:0], new_word};
              widx_q <= widx_q + WIdxW'(1);
              if (widx_q[1:0] == 2'd0) rcon_q <= xtime(rcon_q);
            end else begin
              state_q <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_xfer) begin
              inv_q   <= opcode_i;
              rnd_q   <= '0;
              state_q <= ST_ROUND;
            end
          end
          ST_ROUND: begin
            if (last_rnd) begin
              state_q <= ST_DONE;
            end else begin
              rnd_q <= rnd_next;
            end
          end
          ST_DONE: begin
            if (load_out) state_q <= ST_IDLE;
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  // Output valid: set when a result is loaded, cleared when it is transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_out) begin
      ovalid_q <= 1'b1;
    end else if (out_xfer) begin
      ovalid_q <= 1'b0;
    end
  end

  // Block state and output register.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      blk_q <= {block_upper_i, block_lower_i};
    end else if (state_q == ST_ROUND) begin
      if (rnd_q == '0) blk_q <= blk_q ^ rkey_q;
      else blk_q <= rnd_out;
    end
    if (load_out) begin
      out_q <= blk_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_upper_o = out_q[BlockW-1 -: HalfW];
  assign out_lower_o = out_q[HalfW-1:0];

endmodule

// File: sim/tb.sv
// Testbench for the AES-128 block cipher unit: random and directed blocks
// checked against an in-bench cipher model. Depends on aes128_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
  import aes128_pkg::*;

  typedef struct packed {
    aes_op_e     op;
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } ct_t;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_stall;
  logic        opcode;
  logic [63:0] blk_hi, blk_lo;
  logic        out_valid, out_stall;
  logic [63:0] out_hi, out_lo;

  aes128_block_cipher_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .opcode_i(opcode),
    .block_upper_i(blk_hi), .block_lower_i(blk_lo),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_upper_o(out_hi), .out_lower_o(out_lo)
  );

  // Model state: key halves, schedule and inverse S-box.
  logic [63:0] key_hi_m, key_lo_m;
  logic [31:0] sched [44];
  logic [7:0]  isbox [256];

  blk_t pending_blocks [$];
  ct_t  expected_blocks [$];
  int   mismatches, cycle_count;
  bit   quiet_mode, feed_done, hold_sender;
  int   in_gap, out_gap;

  function automatic logic [7:0] gf_double(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  // Rebuild the 44-word key schedule from both halves.
  function automatic void build_schedule();
    logic [7:0]  rc;
    logic [31:0] t;
    rc = 8'h01;
    sched[0] = key_hi_m[63:32]; sched[1] = key_hi_m[31:0];
    sched[2] = key_lo_m[63:32]; sched[3] = key_lo_m[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]} ^ {rc, 24'h0};
        rc = gf_double(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
  endfunction

  // Full cipher or inverse cipher on one block, state as 16 bytes.
  function automatic ct_t cipher_block(blk_t b);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [4];
    logic [7:0] c [4];
    ct_t res;
    for (int i = 0; i < 8; i++) begin
      s[i] = b.hi[63-8*i -: 8];
      s[8+i] = b.lo[63-8*i -: 8];
    end
    if (b.op == OP_ENCRYPT) m = '{8'h02, 8'h03, 8'h01, 8'h01};
    else m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    for (int step = 0; step <= 10; step++) begin
      int rk;
      rk = (b.op == OP_ENCRYPT) ? step : 10 - step;
      if (step != 0) begin
        for (int r = 0; r < 4; r++)
          for (int cc = 0; cc < 4; cc++)
            t[r+4*cc] = s[r + 4*((cc + ((b.op == OP_ENCRYPT) ? r : 3*r)) % 4)];
        for (int i = 0; i < 16; i++)
          s[i] = (b.op == OP_ENCRYPT) ? SBOX[t[i]] : isbox[t[i]];
        if (b.op == OP_ENCRYPT && step != 10) begin
          for (int cc = 0; cc < 4; cc++) begin
            for (int k = 0; k < 4; k++) c[k] = s[4*cc+k];
            for (int r = 0; r < 4; r++)
              s[4*cc+r] = gf_mul(c[0], m[(4-r)%4]) ^ gf_mul(c[1], m[(5-r)%4]) ^
                          gf_mul(c[2], m[(6-r)%4]) ^ gf_mul(c[3], m[(7-r)%4]);
          end
        end
      end
      for (int cc = 0; cc < 4; cc++)
        for (int k = 0; k < 4; k++)
          s[4*cc+k] ^= sched[4*rk+cc][31-8*k -: 8];
      // Inverse cipher mixes after the key addition of rounds 9 down to 1.
      if (b.op == OP_DECRYPT && step != 0 && step != 10) begin
        for (int cc = 0; cc < 4; cc++) begin
          for (int k = 0; k < 4; k++) c[k] = s[4*cc+k];
          for (int r = 0; r < 4; r++)
            s[4*cc+r] = gf_mul(c[0], m[(4-r)%4]) ^ gf_mul(c[1], m[(5-r)%4]) ^
                        gf_mul(c[2], m[(6-r)%4]) ^ gf_mul(c[3], m[(7-r)%4]);
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[8+i];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h1;
      default: return rand64();
    endcase
  endfunction

  // Clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: present queued blocks, with random idle bursts.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 0;
      opcode <= 0;
      blk_hi <= 0;
      blk_lo <= 0;
      in_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) expected_blocks.push_back(cipher_block('{aes_op_e'(opcode), blk_hi, blk_lo}));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (pending_blocks.size() > 0 && !hold_sender) begin
        blk_t b;
        b = pending_blocks.pop_front();
        in_valid <= 1;
        opcode <= b.op;
        blk_hi <= b.hi;
        blk_lo <= b.lo;
        if (!quiet_mode && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 5);
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Monitor: check each result transfer and drive random stalls.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 0;
      out_gap <= 0;
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $display("unexpected result %h %h at cycle %0d", out_hi, out_lo, cycle_count);
          mismatches++;
        end else begin
          ct_t e;
          e = expected_blocks.pop_front();
          if (out_hi !== e.hi) report_mismatch("out_upper", out_hi, e.hi);
          if (out_lo !== e.lo) report_mismatch("out_lower", out_lo, e.lo);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1;
      end else if (!quiet_mode && $urandom_range(0, 6) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
      if (cycle_count > 400000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Wait until the block has delivered everything queued so far.
  task automatic wait_drained();
    while (pending_blocks.size() > 0 || in_valid || expected_blocks.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write one key half while idle; the model follows at once.
  task automatic write_key(logic [0:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == RegKeyUpper) key_hi_m = val;
    else key_lo_m = val;
    build_schedule();
  endtask

  task automatic queue_block(aes_op_e op, logic [63:0] hi, logic [63:0] lo);
    pending_blocks.push_back('{op, hi, lo});
  endtask

  // Stimulus: directed blocks, then random phases under several keys.
  initial begin
    for (int i = 0; i < 256; i++) isbox[SBOX[i]] = i[7:0];
    key_hi_m = 0;
    key_lo_m = 0;
    build_schedule();
    mismatches = 0;
    quiet_mode = 0;
    hold_sender = 0;
    cfg_we = 0;
    cfg_index = RegKeyUpper;
    cfg_data = 0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // Directed: reset key, extremes of the block, both operations.
    queue_block(OP_ENCRYPT, 64'h0, 64'h0);
    queue_block(OP_DECRYPT, 64'h0, 64'h0);
    queue_block(OP_ENCRYPT, '1, '1);
    queue_block(OP_DECRYPT, '1, '1);
    wait_drained();
    // Standard test vector key, then single-half rewrites.
    write_key(RegKeyUpper, 64'h0001_0203_0405_0607);
    write_key(RegKeyLower, 64'h0809_0a0b_0c0d_0e0f);
    queue_block(OP_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    queue_block(OP_DECRYPT, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    queue_block(OP_ENCRYPT, 64'h8000_0000_0000_0000, 64'h1);
    wait_drained();
    write_key(RegKeyLower, '1);
    queue_block(OP_ENCRYPT, '1, 64'h0);
    queue_block(OP_DECRYPT, 64'h0, '1);
    wait_drained();
    write_key(RegKeyUpper, '1);
    queue_block(OP_ENCRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    queue_block(OP_DECRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    wait_drained();

    // Random phases, each under a new key; one phase runs without idling.
    for (int ph = 0; ph < 8; ph++) begin
      write_key(RegKeyUpper, ph == 0 ? 64'h0 : edge_value());
      write_key(RegKeyLower, ph == 1 ? 64'h0 : edge_value());
      if (ph == 7) quiet_mode = 1;
      for (int n = 0; n < 200; n++) begin
        queue_block(aes_op_e'($urandom_range(0, 1)), edge_value(), edge_value());
        // Sender holds off until every result is back.
        if (n == 100) begin
          while (pending_blocks.size() > 0) @(posedge clk);
          hold_sender = 1;
          while (in_valid || expected_blocks.size() > 0) @(posedge clk);
          hold_sender = 0;
        end
      end
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: aes128_block_cipher_unit.f
design/aes128_pkg.sv
design/aes128_round.sv
design/aes128_block_cipher_unit.sv
sim/tb.sv
